// File: hw/rtl/cpi_pkg.sv
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared constants, types and helpers for the complex power integrator.
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam int MAX_ELEMENTS = 8192;
    localparam int MAX_WINDOW   = 1024;

    localparam int SAMPLE_W = 8;     // packed input word
    localparam int POWER_W  = 8;     // re^2 + im^2, 0..128
    localparam int ELEM_W   = 13;    // element position / index
    localparam int WIN_W    = 10;    // window position
    localparam int SUM_W    = 18;    // accumulator entry
    localparam int AVG_W    = 16;    // averaged output
    localparam int FRAC_W   = 8;     // fraction bits of the average
    localparam int WLEN_W   = 11;    // window_length register
    localparam int SELEM_W  = 14;    // sample_elements register

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ELEMENTS = 1'd1;

    localparam logic [WLEN_W-1:0]  WLEN_RST  = 11'd100;
    localparam logic [SELEM_W-1:0] SELEM_RST = 14'd6144;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [ELEM_W-1:0] pos;
        logic              last;
    } t_div_req;

    typedef struct packed {
        logic [AVG_W-1:0]  avg;
        logic [ELEM_W-1:0] pos;
        logic              last;
    } t_div_rsp;

    // Square of a 4-bit two's-complement nibble, 0..64.
    function automatic logic [6:0] nibble_square(input logic [3:0] nib);
        logic [3:0] mag;
        logic [7:0] sq;
        mag = nib[3] ? (~nib + 4'd1) : nib;
        sq  = {4'd0, mag} * {4'd0, mag};
        return sq[6:0];
    endfunction

endpackage

// File: hw/rtl/cpi_in_if.sv
// ----------------------------------------------------------------------------
// cpi_in_if
// Input channel: one packed complex sample word per transfer.
// ----------------------------------------------------------------------------
interface cpi_in_if;
    import cpi_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] packed_sample;

    modport source (output valid, output packed_sample, input ready);
    modport sink   (input valid, input packed_sample, output ready);
endinterface

// File: hw/rtl/cpi_out_if.sv
// ----------------------------------------------------------------------------
// cpi_out_if
// Output channel: one averaged power word per transfer.
// ----------------------------------------------------------------------------
interface cpi_out_if;
    import cpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [AVG_W-1:0]  average_power;
    logic [ELEM_W-1:0] element_index;
    logic              frame_last;

    modport source (output valid, output average_power, output element_index,
                    output frame_last, input ready);
    modport sink   (input valid, input average_power, input element_index,
                    input frame_last, output ready);
endinterface

// File: hw/rtl/cpi_divider.sv
// ----------------------------------------------------------------------------
// cpi_divider
// Pipelined restoring divider: (sum * 256) / window_length, two quotient
// bits per stage, saturating at the top of the output range.
// ----------------------------------------------------------------------------
module cpi_divider
    import cpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_div_req          i_req,
    input  logic [WLEN_W-1:0] i_divisor,
    output logic              o_valid,
    output t_div_rsp          o_rsp
);

    localparam int STEPS = AVG_W / 2;

    logic              r_valid [0:STEPS];
    logic [WLEN_W-1:0] r_rem   [0:STEPS];
    logic [AVG_W-1:0]  r_num   [0:STEPS];
    logic [AVG_W-1:0]  r_quo   [0:STEPS];
    logic [ELEM_W-1:0] r_pos   [0:STEPS];
    logic              r_last  [0:STEPS];
    logic              r_sat   [1:STEPS];

    logic [WLEN_W-1:0] n_rem [1:STEPS];
    logic [1:0]        n_q   [1:STEPS];

    // Shift in two dividend bits, trial-subtract after each.
    function automatic logic [WLEN_W+1:0] div_step(input logic [WLEN_W-1:0] rem,
                                                   input logic [1:0] bits,
                                                   input logic [WLEN_W-1:0] d);
        logic [WLEN_W:0]   t;
        logic [WLEN_W-1:0] r;
        logic [1:0]        q;
        r = rem;
        q = 2'b00;
        for (int k = 1; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[k] = 1'b1;
            end
            r = t[WLEN_W-1:0];
        end
        return {q, r};
    endfunction

    always_comb begin
        for (int i = 1; i <= STEPS; i++) begin
            {n_q[i], n_rem[i]} = div_step(r_rem[i-1], r_num[i-1][AVG_W-1 -: 2], i_divisor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= STEPS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int i = 1; i <= STEPS; i++) begin
                r_valid[i] <= r_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= {1'b0, i_req.sum[SUM_W-1:FRAC_W]};
            r_num[0]  <= {i_req.sum[FRAC_W-1:0], {(AVG_W-FRAC_W){1'b0}}};
            r_quo[0]  <= '0;
            r_pos[0]  <= i_req.pos;
            r_last[0] <= i_req.last;
            // quotient overflows when the high part alone reaches the divisor
            r_sat[1]  <= (r_rem[0] >= i_divisor);
            for (int i = 1; i <= STEPS; i++) begin
                r_rem[i]  <= n_rem[i];
                r_num[i]  <= {r_num[i-1][AVG_W-3:0], 2'b00};
                r_quo[i]  <= {r_quo[i-1][AVG_W-3:0], n_q[i]};
                r_pos[i]  <= r_pos[i-1];
                r_last[i] <= r_last[i-1];
            end
            for (int i = 2; i <= STEPS; i++) begin
                r_sat[i] <= r_sat[i-1];
            end
        end
    end

    assign o_valid    = r_valid[STEPS];
    assign o_rsp.avg  = r_sat[STEPS] ? {AVG_W{1'b1}} : r_quo[STEPS];
    assign o_rsp.pos  = r_pos[STEPS];
    assign o_rsp.last = r_last[STEPS];

endmodule

// File: hw/rtl/complex_power_integrator.sv
// ----------------------------------------------------------------------------
// complex_power_integrator
// Power detect of 4-bit complex words, per-element integration in a
// block memory, and averaged frame output once per integration window.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled, set by the
//   single read-modify-write pass through the sum memory (one read and one write port).
// Pipeline: the memory read is issued at the accepting edge, then 1 divider
//   load, 8 divider stages of 2 bits each and 1 output register.
// Reset: the 8192-entry sum memory is cleared one entry a cycle, so input
//   ready stays low until the clear pass ends; config writes are taken.
module complex_power_integrator
    import cpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cpi_in_if.sink                i_in,
    cpi_out_if.source             o_out
);

    // configuration
    logic [WLEN_W-1:0]  r_window_length;
    logic [SELEM_W-1:0] r_sample_elements;
    logic [WLEN_W-1:0]  wlen;
    logic [SELEM_W-1:0] selem;

    // counters and clear pass
    logic [ELEM_W-1:0] r_elem_pos;
    logic [WIN_W-1:0]  r_win_pos;
    logic              r_clr_active;
    logic [ELEM_W-1:0] r_clr_addr;

    // sum memory
    logic [SUM_W-1:0]  r_sums [0:MAX_ELEMENTS-1];
    logic [SUM_W-1:0]  r_rdata;
    logic              mem_we;
    logic [ELEM_W-1:0] mem_waddr;
    logic [SUM_W-1:0]  mem_wdata;

    // update stage
    logic              r_s1_valid;
    logic [ELEM_W-1:0] r_s1_pos;
    logic [POWER_W-1:0] r_s1_power;
    logic              r_s1_last_win;
    logic              r_s1_last_pos;
    logic              r_s1_fwd;
    logic [ELEM_W-1:0] r_wb_addr;
    logic [SUM_W-1:0]  r_wb_data;

    logic              adv;
    logic              accept;
    logic              last_pos;
    logic              last_win;
    logic [POWER_W-1:0] power;
    logic              s1_we;
    logic [SUM_W-1:0]  s1_base;
    logic [SUM_W:0]    s1_add;
    logic [SUM_W-1:0]  s1_sum;

    // divider and output
    t_div_req          div_req;
    logic              div_valid;
    t_div_rsp          div_rsp;
    logic              r_out_valid;
    t_div_rsp          r_out;

    // clamp out-of-range settings
    always_comb begin
        if (r_window_length == '0) begin
            wlen = WLEN_W'(1);
        end else if (r_window_length > WLEN_W'(MAX_WINDOW)) begin
            wlen = WLEN_W'(MAX_WINDOW);
        end else begin
            wlen = r_window_length;
        end
        if (r_sample_elements == '0) begin
            selem = SELEM_W'(1);
        end else if (r_sample_elements > SELEM_W'(MAX_ELEMENTS)) begin
            selem = SELEM_W'(MAX_ELEMENTS);
        end else begin
            selem = r_sample_elements;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= WLEN_RST;
            r_sample_elements <= SELEM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_LENGTH:   r_window_length   <= i_cfg_data[WLEN_W-1:0];
                REG_SAMPLE_ELEMENTS: r_sample_elements <= i_cfg_data[SELEM_W-1:0];
                default: ;
            endcase
        end
    end

    // the pipe moves unless a finished result finds the output register full and not taken
    assign adv        = !(div_valid && r_out_valid && !o_out.ready);
    assign i_in.ready = adv && !r_clr_active;
    assign accept     = i_in.valid && i_in.ready;

    assign power    = {1'b0, nibble_square(i_in.packed_sample[7:4])}
                    + {1'b0, nibble_square(i_in.packed_sample[3:0])};
    assign last_pos = ({1'b0, r_elem_pos} + SELEM_W'(1)) >= selem;
    assign last_win = ({1'b0, r_win_pos} + WLEN_W'(1)) >= wlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_pos <= '0;
            r_win_pos  <= '0;
        end else if (accept) begin
            if (last_pos) begin
                r_elem_pos <= '0;
                r_win_pos  <= last_win ? '0 : r_win_pos + WIN_W'(1);
            end else begin
                r_elem_pos <= r_elem_pos + ELEM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + ELEM_W'(1);
            if (r_clr_addr == ELEM_W'(MAX_ELEMENTS - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // update stage: add power to the stored sum and write it back (zero on the last window)
    assign s1_we   = r_s1_valid && adv;
    // take the value written at the edge this read was issued
    assign s1_base = r_s1_fwd ? r_wb_data : r_rdata;
    assign s1_add  = {1'b0, s1_base} + (SUM_W+1)'(r_s1_power);
    assign s1_sum  = s1_add[SUM_W] ? SUM_MAX : s1_add[SUM_W-1:0];

    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_we;
            mem_waddr = r_s1_pos;
            mem_wdata = r_s1_last_win ? '0 : s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sums[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rdata <= r_sums[r_elem_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s1_fwd   <= accept && s1_we && (r_elem_pos == r_s1_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos      <= r_elem_pos;
            r_s1_power    <= power;
            r_s1_last_win <= last_win;
            r_s1_last_pos <= last_pos;
        end
        if (s1_we) begin
            r_wb_addr <= r_s1_pos;
            r_wb_data <= mem_wdata;
        end
    end

    assign div_req.sum  = s1_sum;
    assign div_req.pos  = r_s1_pos;
    assign div_req.last = r_s1_last_pos;

    cpi_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (r_s1_valid && r_s1_last_win),
        .i_req     (div_req),
        .i_divisor (wlen),
        .o_valid   (div_valid),
        .o_rsp     (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_valid && adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_valid && adv) begin
            r_out <= div_rsp;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.average_power = r_out.avg;
    assign o_out.element_index = r_out.pos;
    assign o_out.frame_last    = r_out.last;

    // no word enters while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_in.ready)
        else $error("word accepted during clear pass");

    // clear pass and update writes never collide
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_s1_valid)
        else $error("update stage busy during clear pass");

    // forwarded data always comes from the same entry
    a_fwd_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> (r_wb_addr == r_s1_pos))
        else $error("forwarding from a different entry");

    // a blocked result holds the whole pipe
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid && r_out_valid && !o_out.ready) |=> div_valid)
        else $error("divider result lost while output stalled");

endmodule
